// ----- src/bspal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspal_pkg: shared types and constants for the bsp point area locator
// Holds table entry layouts, opcodes, sequencer states and the control
// bundle that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package bspal_pkg;

    // default table depths and walk limit
    localparam int NODE_DEPTH_DEF  = 4096;
    localparam int PLANE_DEPTH_DEF = 4096;
    localparam int MAX_STEPS_DEF   = 4096;

    // fixed field widths
    localparam int COORD_W = 32;
    localparam int CHILD_W = 13;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 16;

    // item opcodes
    typedef enum logic [1:0] {
        OP_WR_PLANE = 2'd0,
        OP_WR_NODE  = 2'd1,
        OP_QUERY    = 2'd2,
        OP_NONE     = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam logic CFG_NODE_COUNT  = 1'b0;
    localparam logic CFG_PLANE_COUNT = 1'b1;

    // plane table entry: a*x + b*y + c*z + d
    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] d;
    } t_plane;

    // node table entry
    typedef struct packed {
        logic signed [CHILD_W-1:0] front;
        logic signed [CHILD_W-1:0] back;
        logic        [INDEX_W-1:0] plane;
    } t_node;

    // term selected for the shared multiplier
    typedef enum logic [1:0] {
        TERM_AX = 2'd0,
        TERM_BY = 2'd1,
        TERM_CZ = 2'd2,
        TERM_D  = 2'd3
    } t_term;

    // control bundle for the multiply-accumulate unit
    typedef struct packed {
        logic  mul_en;
        logic  acc_clear;
        logic  acc_en;
        t_term term;
    } t_mac_ctrl;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NODE_RD,
        ST_NODE_CHK,
        ST_MUL,
        ST_ACC,
        ST_DECIDE,
        ST_DONE
    } t_state;

endpackage

// ----- src/bsp_point_area_locator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_point_area_locator: walks a bsp tree to find the area of a point
// Writes and unused items: go from idle through the done state to the output register.
// Queries: per visited node a node read, a plane read, four passes through the
// shared multiplier, an accumulate and a branch; early exits end the walk sooner.
// One item at a time: the next input is taken when the result is first offered.
// Sync reset clears the sequencer, output valid and counts, not the tables.
// ----------------------------------------------------------------------------
module bsp_point_area_locator #(
    parameter int NODE_DEPTH  = bspal_pkg::NODE_DEPTH_DEF,
    parameter int PLANE_DEPTH = bspal_pkg::PLANE_DEPTH_DEF,
    parameter int MAX_STEPS   = bspal_pkg::MAX_STEPS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [bspal_pkg::COUNT_W-1:0]         i_cfg_data,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_opcode,
    input  logic [bspal_pkg::INDEX_W-1:0]         i_entry_index,
    input  logic signed [bspal_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [bspal_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [bspal_pkg::COORD_W-1:0]  i_coord_z,
    input  logic signed [bspal_pkg::COORD_W-1:0]  i_plane_offset,
    input  logic signed [bspal_pkg::CHILD_W-1:0]  i_child_front,
    input  logic signed [bspal_pkg::CHILD_W-1:0]  i_child_back,
    input  logic [bspal_pkg::INDEX_W-1:0]         i_node_plane,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [bspal_pkg::COUNT_W-1:0]         o_area_number,
    output logic                                  o_is_query_result
);

    localparam int NAW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int PAW = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
    localparam int SW  = $clog2(MAX_STEPS + 1);

    // configuration registers
    logic [bspal_pkg::COUNT_W-1:0] r_node_count;
    logic [bspal_pkg::COUNT_W-1:0] r_plane_count;

    // sequencer registers
    bspal_pkg::t_state             r_state, n_state;
    bspal_pkg::t_term              r_term, n_term;
    logic [NAW-1:0]                r_node, n_node;
    logic [SW-1:0]                 r_steps, n_steps;
    logic [bspal_pkg::COUNT_W-1:0] r_res_area, n_res_area;
    logic                          r_res_query, n_res_query;
    logic signed [bspal_pkg::COORD_W-1:0] r_x, r_y, r_z;

    // output register
    logic                          r_out_valid, n_out_valid;
    logic [bspal_pkg::COUNT_W-1:0] r_out_area, n_out_area;
    logic                          r_out_query, n_out_query;

    // table and mac interface
    bspal_pkg::t_node              s_node_wdata;
    bspal_pkg::t_plane             s_plane_wdata;
    bspal_pkg::t_node              s_node_rdata;
    bspal_pkg::t_plane             s_plane_rdata;
    logic                          s_node_we, s_plane_we;
    logic                          s_node_re, s_plane_re;
    bspal_pkg::t_mac_ctrl          s_mac_ctrl;
    logic                          s_front;

    logic                          s_in_xfer;
    logic                          s_out_free;
    bspal_pkg::t_opcode            s_op;
    logic signed [bspal_pkg::CHILD_W-1:0] s_child;
    logic                          s_plane_ok;
    logic                          s_child_ok;

    assign s_op       = bspal_pkg::t_opcode'(i_opcode);
    assign s_in_xfer  = i_in_valid && (r_state == bspal_pkg::ST_IDLE);
    assign s_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != bspal_pkg::ST_IDLE);

    // table writes happen at the input transfer
    assign s_plane_we = s_in_xfer && (s_op == bspal_pkg::OP_WR_PLANE)
                        && (32'(i_entry_index) < PLANE_DEPTH);
    assign s_node_we  = s_in_xfer && (s_op == bspal_pkg::OP_WR_NODE)
                        && (32'(i_entry_index) < NODE_DEPTH);
    assign s_plane_wdata = '{a: i_coord_x, b: i_coord_y, c: i_coord_z, d: i_plane_offset};
    assign s_node_wdata  = '{front: i_child_front, back: i_child_back, plane: i_node_plane};

    // walk checks on the fetched node
    assign s_plane_ok = ({1'b0, s_node_rdata.plane} < r_plane_count)
                        && (32'(s_node_rdata.plane) < PLANE_DEPTH);
    assign s_child    = s_front ? s_node_rdata.front : s_node_rdata.back;
    assign s_child_ok = !s_child[bspal_pkg::CHILD_W-1] && (s_child != '0)
                        && (unsigned'(s_child) < r_node_count)
                        && (32'(unsigned'(s_child)) < NODE_DEPTH);

    bspal_tables #(
        .NODE_DEPTH  (NODE_DEPTH),
        .PLANE_DEPTH (PLANE_DEPTH),
        .NAW         (NAW),
        .PAW         (PAW)
    ) u_tables (
        .i_clk         (i_clk),
        .i_node_we     (s_node_we),
        .i_node_waddr  (NAW'(i_entry_index)),
        .i_node_wdata  (s_node_wdata),
        .i_node_re     (s_node_re),
        .i_node_raddr  (r_node),
        .o_node_rdata  (s_node_rdata),
        .i_plane_we    (s_plane_we),
        .i_plane_waddr (PAW'(i_entry_index)),
        .i_plane_wdata (s_plane_wdata),
        .i_plane_re    (s_plane_re),
        .i_plane_raddr (PAW'(s_node_rdata.plane)),
        .o_plane_rdata (s_plane_rdata)
    );

    bspal_mac u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (s_mac_ctrl),
        .i_plane (s_plane_rdata),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_z     (r_z),
        .o_front (s_front)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count  <= '0;
            r_plane_count <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == bspal_pkg::CFG_NODE_COUNT) begin
                r_node_count <= i_cfg_data;
            end else begin
                r_plane_count <= i_cfg_data;
            end
        end
    end

    // sequencer next state and controls
    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_node      = r_node;
        n_steps     = r_steps;
        n_res_area  = r_res_area;
        n_res_query = r_res_query;
        n_out_valid = r_out_valid;
        n_out_area  = r_out_area;
        n_out_query = r_out_query;
        s_node_re   = 1'b0;
        s_plane_re  = 1'b0;
        s_mac_ctrl  = '{mul_en: 1'b0, acc_clear: 1'b0, acc_en: 1'b0, term: r_term};

        // output transfer frees the output register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bspal_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_res_area  = '0;
                    n_res_query = (s_op == bspal_pkg::OP_QUERY);
                    n_node      = NAW'(1);
                    n_steps     = '0;
                    if (s_op == bspal_pkg::OP_QUERY && r_node_count > 13'd1) begin
                        n_state = bspal_pkg::ST_NODE_RD;
                    end else begin
                        n_state = bspal_pkg::ST_DONE;
                    end
                end
            end
            bspal_pkg::ST_NODE_RD: begin
                if (r_steps == SW'(MAX_STEPS)) begin
                    n_res_area = '0;
                    n_state    = bspal_pkg::ST_DONE;
                end else begin
                    n_steps   = r_steps + SW'(1);
                    s_node_re = 1'b1;
                    n_state   = bspal_pkg::ST_NODE_CHK;
                end
            end
            bspal_pkg::ST_NODE_CHK: begin
                if (!s_plane_ok) begin
                    n_res_area = '0;
                    n_state    = bspal_pkg::ST_DONE;
                end else begin
                    s_plane_re = 1'b1;
                    n_term     = bspal_pkg::TERM_AX;
                    n_state    = bspal_pkg::ST_MUL;
                end
            end
            bspal_pkg::ST_MUL: begin
                // multiply this term, accumulate the previous product
                s_mac_ctrl.mul_en    = 1'b1;
                s_mac_ctrl.acc_clear = (r_term == bspal_pkg::TERM_AX);
                s_mac_ctrl.acc_en    = (r_term != bspal_pkg::TERM_AX);
                case (r_term)
                    bspal_pkg::TERM_AX: n_term = bspal_pkg::TERM_BY;
                    bspal_pkg::TERM_BY: n_term = bspal_pkg::TERM_CZ;
                    bspal_pkg::TERM_CZ: n_term = bspal_pkg::TERM_D;
                    default: begin
                        n_term  = bspal_pkg::TERM_AX;
                        n_state = bspal_pkg::ST_ACC;
                    end
                endcase
            end
            bspal_pkg::ST_ACC: begin
                s_mac_ctrl.acc_en = 1'b1;
                n_state           = bspal_pkg::ST_DECIDE;
            end
            bspal_pkg::ST_DECIDE: begin
                // branch on the side of the plane
                if (s_child[bspal_pkg::CHILD_W-1]) begin
                    n_res_area = unsigned'(-s_child);
                    n_state    = bspal_pkg::ST_DONE;
                end else if (!s_child_ok) begin
                    n_res_area = '0;
                    n_state    = bspal_pkg::ST_DONE;
                end else begin
                    n_node  = NAW'(unsigned'(s_child));
                    n_state = bspal_pkg::ST_NODE_RD;
                end
            end
            bspal_pkg::ST_DONE: begin
                if (s_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_area  = r_res_area;
                    n_out_query = r_res_query;
                    n_state     = bspal_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bspal_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bspal_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_term      <= n_term;
        r_node      <= n_node;
        r_steps     <= n_steps;
        r_res_area  <= n_res_area;
        r_res_query <= n_res_query;
        r_out_area  <= n_out_area;
        r_out_query <= n_out_query;
        if (s_in_xfer) begin
            r_x <= i_coord_x;
            r_y <= i_coord_y;
            r_z <= i_coord_z;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_area_number     = r_out_area;
    assign o_is_query_result = r_out_query;

endmodule

// ----- src/bspal_tables.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspal_tables: node and plane table memories
// One write port and one registered read port per table, read enables
// hold the read data while the walk works on it.
// ----------------------------------------------------------------------------
module bspal_tables #(
    parameter int NODE_DEPTH  = bspal_pkg::NODE_DEPTH_DEF,
    parameter int PLANE_DEPTH = bspal_pkg::PLANE_DEPTH_DEF,
    parameter int NAW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1,
    parameter int PAW = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_node_we,
    input  logic [NAW-1:0]     i_node_waddr,
    input  bspal_pkg::t_node   i_node_wdata,
    input  logic               i_node_re,
    input  logic [NAW-1:0]     i_node_raddr,
    output bspal_pkg::t_node   o_node_rdata,
    input  logic               i_plane_we,
    input  logic [PAW-1:0]     i_plane_waddr,
    input  bspal_pkg::t_plane  i_plane_wdata,
    input  logic               i_plane_re,
    input  logic [PAW-1:0]     i_plane_raddr,
    output bspal_pkg::t_plane  o_plane_rdata
);

    bspal_pkg::t_node  r_node_mem  [NODE_DEPTH];
    bspal_pkg::t_plane r_plane_mem [PLANE_DEPTH];
    bspal_pkg::t_node  r_node_rdata;
    bspal_pkg::t_plane r_plane_rdata;

    // node table
    always_ff @(posedge i_clk) begin
        if (i_node_we) begin
            r_node_mem[i_node_waddr] <= i_node_wdata;
        end
        if (i_node_re) begin
            r_node_rdata <= r_node_mem[i_node_raddr];
        end
    end

    // plane table
    always_ff @(posedge i_clk) begin
        if (i_plane_we) begin
            r_plane_mem[i_plane_waddr] <= i_plane_wdata;
        end
        if (i_plane_re) begin
            r_plane_rdata <= r_plane_mem[i_plane_raddr];
        end
    end

    assign o_node_rdata  = r_node_rdata;
    assign o_plane_rdata = r_plane_rdata;

endmodule

// ----- src/bspal_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspal_mac: shared multiply-accumulate unit for the plane side test
// One 32x32 signed multiplier feeds a product register, which feeds a
// wide accumulator; the accumulator sign gives the side of the plane.
// ----------------------------------------------------------------------------
module bspal_mac (
    input  logic                                   i_clk,
    input  bspal_pkg::t_mac_ctrl                   i_ctrl,
    input  bspal_pkg::t_plane                      i_plane,
    input  logic signed [bspal_pkg::COORD_W-1:0]   i_x,
    input  logic signed [bspal_pkg::COORD_W-1:0]   i_y,
    input  logic signed [bspal_pkg::COORD_W-1:0]   i_z,
    output logic                                   o_front
);

    logic signed [bspal_pkg::COORD_W-1:0] s_op_a;
    logic signed [bspal_pkg::COORD_W-1:0] s_op_b;
    logic signed [bspal_pkg::PROD_W-1:0]  s_prod;
    logic signed [bspal_pkg::PROD_W-1:0]  r_prod;
    logic signed [bspal_pkg::ACC_W-1:0]   r_acc;

    // operand select
    always_comb begin
        case (i_ctrl.term)
            bspal_pkg::TERM_AX: begin
                s_op_a = i_plane.a;
                s_op_b = i_x;
            end
            bspal_pkg::TERM_BY: begin
                s_op_a = i_plane.b;
                s_op_b = i_y;
            end
            bspal_pkg::TERM_CZ: begin
                s_op_a = i_plane.c;
                s_op_b = i_z;
            end
            default: begin
                s_op_a = i_plane.d;
                s_op_b = '0;
            end
        endcase
    end

    // offset term is d scaled to q32.32, no multiply needed
    always_comb begin
        if (i_ctrl.term == bspal_pkg::TERM_D) begin
            s_prod = {{(bspal_pkg::PROD_W - bspal_pkg::COORD_W - bspal_pkg::FRAC_W)
                       {s_op_a[bspal_pkg::COORD_W-1]}},
                      s_op_a, {bspal_pkg::FRAC_W{1'b0}}};
        end else begin
            s_prod = s_op_a * s_op_b;
        end
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= s_prod;
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clear) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + {{(bspal_pkg::ACC_W - bspal_pkg::PROD_W){r_prod[bspal_pkg::PROD_W-1]}},
                              r_prod};
        end
    end

    assign o_front = ~r_acc[bspal_pkg::ACC_W-1];

endmodule
